/* src/stif_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stif_pkg;

  // Table size and the widths that follow from it.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed widths of the item fields.
  localparam int VALUE_W     = 64;
  localparam int POS_W       = 4;
  localparam int COUNT_OUT_W = 5;

  // Operation codes of the kind field.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* src/sorted_table_insert_find_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    in_kind, in_value
// out_     output     out_valid/out_stall  out_found, out_position, out_refused,
//                                          out_entry_count
//
// Entries live in one synchronous RAM with one write and one read port.
// A find reads upward from index 0 and stops at the first match; an insert reads downward
// from the last entry, moving each larger entry up one slot. An insert that lands at the front
// writes index 0 in ST_PLACE; full and empty cases go from ST_IDLE straight to ST_DONE.
// Reset clears the entry count and control only. A new item is taken while the previous
// result waits on out_stall; the next result then holds in ST_DONE until the register frees.

module sorted_table_insert_find_core
  import stif_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_kind,
  input  wire logic [VALUE_W-1:0]     in_value,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_found,
  output logic [POS_W-1:0]            out_position,
  output logic                        out_refused,
  output logic [COUNT_OUT_W-1:0]      out_entry_count
);

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic               kind_r;
  logic [VALUE_W-1:0] value_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               res_found_r, res_found_nxt;
  logic [IDX_W-1:0]   res_pos_r, res_pos_nxt;
  logic               res_refused_r, res_refused_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [IDX_W-1:0]   out_pos_r;
  logic               out_refused_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               in_take;
  logic               out_load;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [IDX_W-1:0]   last_idx;
  logic               full;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    res_found_nxt   = res_found_r;
    res_pos_nxt     = res_pos_r;
    res_refused_nxt = res_refused_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = value_r;
    out_load        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res_found_nxt   = 1'b0;
          res_pos_nxt     = '0;
          res_refused_nxt = 1'b0;
          if (in_kind == KIND_INSERT) begin
            if (full) begin
              res_refused_nxt = 1'b1;
              state_nxt       = ST_DONE;
            end else if (count_r == '0) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = in_value;
              count_nxt = count_r + CNT_W'(1);
              state_nxt = ST_DONE;
            end else begin
              // Walk down from the last entry.
              rd_en     = 1'b1;
              rd_addr   = last_idx;
              idx_nxt   = last_idx;
              state_nxt = ST_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (kind_r == KIND_INSERT) begin
          if (value_r < rd_data_r) begin
            // Move the larger entry up one slot; the slot below, if any, is read next.
            wr_en   = 1'b1;
            wr_addr = idx_r + IDX_W'(1);
            wr_data = rd_data_r;
            if (idx_r == '0) begin
              state_nxt = ST_PLACE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_r - IDX_W'(1);
              idx_nxt = idx_r - IDX_W'(1);
            end
          end else begin
            wr_en     = 1'b1;
            wr_addr   = idx_r + IDX_W'(1);
            wr_data   = value_r;
            count_nxt = count_r + CNT_W'(1);
            state_nxt = ST_DONE;
          end
        end else begin
          if (rd_data_r == value_r) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = idx_r;
            state_nxt     = ST_DONE;
          end else if (idx_r == last_idx) begin
            state_nxt = ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_W'(1);
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = value_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    idx_r         <= idx_nxt;
    res_found_r   <= res_found_nxt;
    res_pos_r     <= res_pos_nxt;
    res_refused_r <= res_refused_nxt;
    if (out_load) begin
      out_found_r   <= res_found_r;
      out_pos_r     <= res_pos_r;
      out_refused_r <= res_refused_r;
      out_count_r   <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_position    = POS_W'(out_pos_r);
  assign out_refused     = out_refused_r;
  assign out_entry_count = COUNT_OUT_W'(out_count_r);

endmodule

`default_nettype wire
